// ===== rtl/gtg_pkg.sv =====
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types and constants for the go-to-goal velocity controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int FRAC_BITS     = 12;
    localparam int CORDIC_STAGES = 16;
    localparam int GUARD_BITS    = 8;
    localparam int ANGLE_FRAC    = 30;

    localparam int CFG_W     = 16;
    localparam int POS_W     = 16;
    localparam int HEAD_W    = 15;
    localparam int SPEED_W   = 16;
    localparam int TURN_W    = 15;
    localparam int DIFF_W    = POS_W + 1;
    localparam int XY_W      = 28;
    localparam int Z_W       = 34;
    localparam int KINV_W    = 30;
    localparam int PROD_W    = (XY_W - 1) + KINV_W;
    localparam int DIST_SHIFT = ANGLE_FRAC + GUARD_BITS;
    localparam int DIST_W    = PROD_W - DIST_SHIFT;
    localparam int Z_SHIFT   = ANGLE_FRAC - FRAC_BITS;
    localparam int BEAR_W    = Z_W - Z_SHIFT;
    localparam int ERR_W     = BEAR_W + 1;
    localparam int GPROD_W   = CFG_W + DIST_W;
    localparam int SPEED_FULL_W = GPROD_W - FRAC_BITS;

    localparam logic [KINV_W-1:0]        KINV_Q30    = KINV_W'(652032874);
    localparam logic signed [Z_W-1:0]    HALF_PI_Q30 = Z_W'(1686629713);
    localparam logic [PROD_W-1:0]        DIST_ROUND  = PROD_W'(1) << (DIST_SHIFT - 1);
    localparam logic signed [Z_W-1:0]    Z_ROUND     = Z_W'(1) << (Z_SHIFT - 1);

    localparam int DIST_TH_I = ((1 << FRAC_BITS) + 5) / 10;
    localparam int ANG_TH_I  = ((2 << FRAC_BITS) + 5) / 10;
    localparam logic [DIST_W-1:0] DIST_TH = DIST_W'(DIST_TH_I);
    localparam logic [TURN_W-1:0] ANG_TH  = TURN_W'(ANG_TH_I);

    localparam logic [CFG_W-1:0] AIM_X_RST      = CFG_W'(4096);
    localparam logic [CFG_W-1:0] AIM_Y_RST      = CFG_W'(4096);
    localparam logic [CFG_W-1:0] GAIN_RST       = CFG_W'(4096);
    localparam logic [CFG_W-1:0] SPEED_CEIL_RST = CFG_W'(12288);

    localparam int ATAN_N = 24;
    localparam logic [31:0] ATAN_TBL [ATAN_N] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    typedef enum logic [1:0] {
        CFG_AIM_X      = 2'd0,
        CFG_AIM_Y      = 2'd1,
        CFG_GAIN       = 2'd2,
        CFG_SPEED_CEIL = 2'd3
    } cfg_reg_e;

    typedef struct packed {
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [Z_W-1:0]    z;
        logic signed [HEAD_W-1:0] heading;
    } vec_t;

endpackage

// ===== rtl/gtg_intf.sv =====
// ----------------------------------------------------------------------------
// gtg_intf
// Valid/ready channels for pose samples and velocity commands.
// ----------------------------------------------------------------------------
interface gtg_pose_if;
    import gtg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [POS_W-1:0]         cur_x;
    logic [POS_W-1:0]         cur_y;
    logic signed [HEAD_W-1:0] heading;

    modport source (output valid, output cur_x, output cur_y, output heading, input ready);
    modport sink   (input valid, input cur_x, input cur_y, input heading, output ready);
endinterface

interface gtg_cmd_if;
    import gtg_pkg::*;

    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] linear_speed;
    logic [TURN_W-1:0]  turn_rate;

    modport source (output valid, output linear_speed, output turn_rate, input ready);
    modport sink   (input valid, input linear_speed, input turn_rate, output ready);
endinterface

// ===== rtl/gtg_front.sv =====
// ----------------------------------------------------------------------------
// gtg_front
// Forms the scaled offset to the target and folds it into the right half plane.
// ----------------------------------------------------------------------------
module gtg_front (
    input  logic                         clk,
    input  logic                         rst_n,
    gtg_pose_if.sink                     pose,
    input  logic [gtg_pkg::CFG_W-1:0]    aim_x,
    input  logic [gtg_pkg::CFG_W-1:0]    aim_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output gtg_pkg::vec_t                out_vec
);
    import gtg_pkg::*;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [XY_W-1:0]   dx_s;
    logic signed [XY_W-1:0]   dy_s;
    vec_t                     vec_next;
    vec_t                     vec_reg;
    logic                     valid_reg;
    logic                     ready;

    assign dx = $signed({1'b0, aim_x}) - $signed({1'b0, pose.cur_x});
    assign dy = $signed({1'b0, aim_y}) - $signed({1'b0, pose.cur_y});
    assign dx_s = {{(XY_W - DIFF_W - GUARD_BITS){dx[DIFF_W-1]}}, dx, {GUARD_BITS{1'b0}}};
    assign dy_s = {{(XY_W - DIFF_W - GUARD_BITS){dy[DIFF_W-1]}}, dy, {GUARD_BITS{1'b0}}};

    // rotate a left-half-plane vector by a quarter turn toward +x
    always_comb
    begin
        vec_next.heading = pose.heading;
        if (dx_s[XY_W-1])
        begin
            if (!dy_s[XY_W-1])
            begin
                vec_next.x = dy_s;
                vec_next.y = -dx_s;
                vec_next.z = HALF_PI_Q30;
            end
            else
            begin
                vec_next.x = -dy_s;
                vec_next.y = dx_s;
                vec_next.z = -HALF_PI_Q30;
            end
        end
        else
        begin
            vec_next.x = dx_s;
            vec_next.y = dy_s;
            vec_next.z = '0;
        end
    end

    assign ready      = !valid_reg || out_ready;
    assign pose.ready = ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= pose.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready && pose.valid)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

// ===== rtl/gtg_cordic.sv =====
// ----------------------------------------------------------------------------
// gtg_cordic
// Pipelined CORDIC vectoring, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module gtg_cordic (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gtg_pkg::vec_t in_vec,
    output logic          out_valid,
    input  logic          out_ready,
    output gtg_pkg::vec_t out_vec
);
    import gtg_pkg::*;

    vec_t vec_in  [CORDIC_STAGES+1];
    logic valid_in[CORDIC_STAGES+1];
    logic rdy     [CORDIC_STAGES+1];
    vec_t vec_reg [CORDIC_STAGES];
    logic valid_reg[CORDIC_STAGES];

    assign vec_in[0]            = in_vec;
    assign valid_in[0]          = in_valid;
    assign rdy[CORDIC_STAGES]   = out_ready;
    assign in_ready             = rdy[0];

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        localparam logic signed [Z_W-1:0] ATAN_I = $signed({2'b00, ATAN_TBL[i]});

        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        vec_t                   vec_next;

        always_comb
        begin
            xs       = vec_in[i].x >>> i;
            ys       = vec_in[i].y >>> i;
            vec_next = vec_in[i];
            if (!vec_in[i].y[XY_W-1])
            begin
                vec_next.x = vec_in[i].x + ys;
                vec_next.y = vec_in[i].y - xs;
                vec_next.z = vec_in[i].z + ATAN_I;
            end
            else
            begin
                vec_next.x = vec_in[i].x - ys;
                vec_next.y = vec_in[i].y + xs;
                vec_next.z = vec_in[i].z - ATAN_I;
            end
        end

        assign rdy[i] = !valid_reg[i] || rdy[i+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (rdy[i])
                valid_reg[i] <= valid_in[i];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i] && valid_in[i])
                vec_reg[i] <= vec_next;
        end

        assign vec_in[i+1]   = vec_reg[i];
        assign valid_in[i+1] = valid_reg[i];
    end

    assign out_valid = valid_in[CORDIC_STAGES];
    assign out_vec   = vec_in[CORDIC_STAGES];

endmodule

// ===== rtl/gtg_back.sv =====
// ----------------------------------------------------------------------------
// gtg_back
// Scales the CORDIC magnitude to a distance, rounds the bearing and picks
// between stop, turn in place and drive ahead.
// ----------------------------------------------------------------------------
module gtg_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  gtg_pkg::vec_t             in_vec,
    input  logic [gtg_pkg::CFG_W-1:0] gain,
    input  logic [gtg_pkg::CFG_W-1:0] speed_ceil,
    gtg_cmd_if.source                 cmd
);
    import gtg_pkg::*;

    // stage A: magnitude times 1/K, angle error
    logic [XY_W-2:0]          x_pos;
    logic [PROD_W-1:0]        prod_next;
    logic signed [Z_W-1:0]    z_rnd;
    logic signed [BEAR_W-1:0] bearing;
    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         err_abs;
    logic                     a_valid_reg;
    logic [PROD_W-1:0]        a_prod_reg;
    logic [TURN_W-1:0]        a_aerr_reg;
    logic                     a_ready;

    // stage B: rounded distance and decisions
    logic [PROD_W-1:0]        dist_sum;
    logic [DIST_W-1:0]        dist_next;
    logic                     b_valid_reg;
    logic [DIST_W-1:0]        b_dist_reg;
    logic                     b_near_reg;
    logic                     b_turn_reg;
    logic [TURN_W-1:0]        b_aerr_reg;
    logic                     b_ready;

    // stage C: gain product
    logic                     c_valid_reg;
    logic [GPROD_W-1:0]       c_speed_reg;
    logic                     c_near_reg;
    logic                     c_turn_reg;
    logic [TURN_W-1:0]        c_aerr_reg;
    logic                     c_ready;

    // stage D: output register
    logic [SPEED_FULL_W-1:0]  speed_full;
    logic [SPEED_W-1:0]       speed_sat;
    logic [SPEED_W-1:0]       linear_next;
    logic [TURN_W-1:0]        turn_next;
    logic                     d_valid_reg;
    logic [SPEED_W-1:0]       d_linear_reg;
    logic [TURN_W-1:0]        d_turn_reg;
    logic                     d_ready;

    assign d_ready  = !d_valid_reg || cmd.ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign x_pos     = in_vec.x[XY_W-1] ? '0 : in_vec.x[XY_W-2:0];
    assign prod_next = x_pos * KINV_Q30;
    assign z_rnd     = in_vec.z + Z_ROUND;
    assign bearing   = z_rnd[Z_W-1:Z_SHIFT];
    assign err       = ERR_W'(bearing) - ERR_W'(in_vec.heading);
    assign err_abs   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

    assign dist_sum  = a_prod_reg + DIST_ROUND;
    assign dist_next = dist_sum[PROD_W-1:DIST_SHIFT];

    assign speed_full = c_speed_reg[GPROD_W-1:FRAC_BITS];
    assign speed_sat  = (speed_full > SPEED_FULL_W'(speed_ceil)) ? speed_ceil
                                                                  : SPEED_W'(speed_full);

    always_comb
    begin
        linear_next = '0;
        turn_next   = '0;
        if (!c_near_reg)
        begin
            if (c_turn_reg)
                turn_next = c_aerr_reg;
            else
                linear_next = speed_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
            if (d_ready)
                d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_prod_reg <= prod_next;
            a_aerr_reg <= TURN_W'(err_abs);
        end
        if (b_ready && a_valid_reg)
        begin
            b_dist_reg <= dist_next;
            b_near_reg <= (dist_next <= DIST_TH);
            b_turn_reg <= (a_aerr_reg > ANG_TH);
            b_aerr_reg <= a_aerr_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            c_speed_reg <= gain * b_dist_reg;
            c_near_reg  <= b_near_reg;
            c_turn_reg  <= b_turn_reg;
            c_aerr_reg  <= b_aerr_reg;
        end
        if (d_ready && c_valid_reg)
        begin
            d_linear_reg <= linear_next;
            d_turn_reg   <= turn_next;
        end
    end

    assign cmd.valid        = d_valid_reg;
    assign cmd.linear_speed = d_linear_reg;
    assign cmd.turn_rate    = d_turn_reg;

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> (cmd.linear_speed == '0 || cmd.turn_rate == '0))
        else $error("both speed and turn commanded");

    a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> (cmd.linear_speed <= speed_ceil))
        else $error("linear speed above ceiling");

    a_turn_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.turn_rate != '0) |-> (cmd.turn_rate > ANG_TH))
        else $error("turn command below angle threshold");

    a_near_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && d_ready && c_near_reg) |=>
            (d_linear_reg == '0 && d_turn_reg == '0))
        else $error("command issued inside goal radius");

endmodule

// ===== rtl/go_to_goal_velocity_controller.sv =====
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller
// Pipeline: 21 register stages (1 offset, 16 CORDIC, 4 scaling and decision).
// Throughput: one pose item per cycle; each register stage holds while the
// stage after it is full and stalled, so a stall at cmd backs up stage by stage.
// Reset clears all valid bits and loads the default target, gain and ceiling.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller (
    input  logic                      clk,
    input  logic                      rst_n,
    gtg_pose_if.sink                  pose,
    gtg_cmd_if.source                 cmd,
    input  logic                      cfg_we,
    input  gtg_pkg::cfg_reg_e         cfg_index,
    input  logic [gtg_pkg::CFG_W-1:0] cfg_data
);
    import gtg_pkg::*;

    logic [CFG_W-1:0] aim_x_reg;
    logic [CFG_W-1:0] aim_y_reg;
    logic [CFG_W-1:0] gain_reg;
    logic [CFG_W-1:0] speed_ceil_reg;

    logic front_valid;
    logic front_ready;
    vec_t front_vec;
    logic cordic_valid;
    logic cordic_ready;
    vec_t cordic_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aim_x_reg      <= AIM_X_RST;
            aim_y_reg      <= AIM_Y_RST;
            gain_reg       <= GAIN_RST;
            speed_ceil_reg <= SPEED_CEIL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AIM_X:      aim_x_reg      <= cfg_data;
                CFG_AIM_Y:      aim_y_reg      <= cfg_data;
                CFG_GAIN:       gain_reg       <= cfg_data;
                CFG_SPEED_CEIL: speed_ceil_reg <= cfg_data;
                default:        aim_x_reg      <= aim_x_reg;
            endcase
        end
    end

    gtg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pose      (pose),
        .aim_x     (aim_x_reg),
        .aim_y     (aim_y_reg),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_vec   (front_vec)
    );

    gtg_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_vec    (front_vec),
        .out_valid (cordic_valid),
        .out_ready (cordic_ready),
        .out_vec   (cordic_vec)
    );

    gtg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cordic_valid),
        .in_ready   (cordic_ready),
        .in_vec     (cordic_vec),
        .gain       (gain_reg),
        .speed_ceil (speed_ceil_reg),
        .cmd        (cmd)
    );

endmodule
